// ===== rtl/binary_min_heap_queue_macros.svh =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_macros: assertion helpers
// Concurrent check macros clocked on clk and held off during rst.
// They compile away to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BMHQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmhq: same-cycle check failed");

// next-cycle implication
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmhq: next-cycle check failed");

`else

`define BMHQ_ASSERT_NOW(label, ante, cons)
`define BMHQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg: shared definitions for the binary min-heap queue
// Default sizes, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  // default sizes
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_KEY_WIDTH = 32;
  localparam int DEF_TAG_WIDTH = 10;

  // operation codes carried by kind
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EX_ROOT,
    S_EX_LAST,
    S_DN,
    S_DN_CMP,
    S_UP,
    S_UP_CMP,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue: array-based binary min-heap priority queue
// Insert appends an entry and sifts it up; extract returns the root, moves
// the last entry to the root and sifts it down with a moving hole.
// ----------------------------------------------------------------------------
// One item is processed at a time; the result is held in an output register
// so the next item is taken while it waits. Entries live in one synchronous
// memory (one write port, two registered read ports). Each heap level is
// handled as a memory read followed by a compare-and-write. An insert ends
// without a compare when the entry climbs to the root; an extract ends
// without one when the entry stops at a slot with no children. An extract
// descends at most log2(CAPACITY) - 1 levels and an insert climbs at most
// log2(CAPACITY) levels. Overflow and underflow items go straight to the
// finish state without touching the memory. A result that cannot enter the
// output register because the previous one is still waiting stalls the
// controller in its finish state. The memory needs no clearing pass: only
// entries below the fill count are ever used. Keys compare as signed two's
// complement; ties never move an entry, and on sift-down a tie between the
// two children goes to the right.
`default_nettype none

`include "binary_min_heap_queue_macros.svh"

module binary_min_heap_queue #(
  parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = bmhq_pkg::DEF_KEY_WIDTH,
  parameter int TAG_WIDTH = bmhq_pkg::DEF_TAG_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // input item
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic signed [KEY_WIDTH-1:0]        key,
  input  logic        [TAG_WIDTH-1:0]        tag,
  // result item
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [KEY_WIDTH-1:0]        out_key,
  output logic        [TAG_WIDTH-1:0]        out_tag,
  output logic        [1:0]                  status,
  output logic        [$clog2(CAPACITY+1)-1:0] fill_count
);

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int IDX_W   = ADDR_W + 2;
  localparam int ENTRY_W = KEY_WIDTH + TAG_WIDTH;

  // heap storage
  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  raddr_a;
  logic [ADDR_W-1:0]  raddr_b;
  logic [ENTRY_W-1:0] rd_a;
  logic [ENTRY_W-1:0] rd_b;

  // control state
  bmhq_pkg::state_t state;
  bmhq_pkg::state_t state_next;
  logic [CNT_W-1:0] count;

  // datapath registers
  logic [ENTRY_W-1:0]     cur;
  logic [ADDR_W-1:0]      pos;
  logic                   right_ok;
  logic [KEY_WIDTH-1:0]   res_key;
  logic [TAG_WIDTH-1:0]   res_tag;
  bmhq_pkg::status_t      res_status;

  // derived values
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   out_load;
  logic [IDX_W-1:0]       count_ext;
  logic [IDX_W-1:0]       left_idx;
  logic [IDX_W-1:0]       right_idx;
  logic [ADDR_W-1:0]      parent;
  logic                   left_ok;
  logic                   r_gt_l;
  logic                   cur_gt_l;
  logic                   cur_gt_r;
  logic                   take_left;
  logic                   dn_swap;
  logic                   up_climb;
  logic [ENTRY_W-1:0]     pick_entry;
  logic [ADDR_W-1:0]      pick_idx;

  assign accept    = in_valid && in_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign out_load  = !out_valid || out_ready;
  assign count_ext = IDX_W'(count);

  // tree addressing around the hole
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + 1'b1;
  assign parent    = ADDR_W'((pos - 1'b1) >> 1);
  assign left_ok   = (left_idx < count_ext);

  // sift-down child selection, ties go right
  assign r_gt_l     = $signed(rd_b[ENTRY_W-1 -: KEY_WIDTH]) >
                      $signed(rd_a[ENTRY_W-1 -: KEY_WIDTH]);
  assign cur_gt_l   = $signed(cur[ENTRY_W-1 -: KEY_WIDTH]) >
                      $signed(rd_a[ENTRY_W-1 -: KEY_WIDTH]);
  assign cur_gt_r   = $signed(cur[ENTRY_W-1 -: KEY_WIDTH]) >
                      $signed(rd_b[ENTRY_W-1 -: KEY_WIDTH]);
  assign take_left  = !right_ok || r_gt_l;
  assign dn_swap    = take_left ? cur_gt_l : cur_gt_r;
  assign pick_entry = take_left ? rd_a : rd_b;
  assign pick_idx   = take_left ? left_idx[ADDR_W-1:0] : right_idx[ADDR_W-1:0];

  // sift-up compare against the parent
  assign up_climb = $signed(rd_a[ENTRY_W-1 -: KEY_WIDTH]) >
                    $signed(cur[ENTRY_W-1 -: KEY_WIDTH]);

  // memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          if (kind == bmhq_pkg::KIND_EXTRACT) begin
            state_next = empty ? bmhq_pkg::S_FINISH : bmhq_pkg::S_EX_ROOT;
          end else begin
            state_next = full ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP;
          end
        end
      end
      bmhq_pkg::S_EX_ROOT: state_next = bmhq_pkg::S_EX_LAST;
      bmhq_pkg::S_EX_LAST: state_next = bmhq_pkg::S_DN;
      bmhq_pkg::S_DN: begin
        state_next = left_ok ? bmhq_pkg::S_DN_CMP : bmhq_pkg::S_FINISH;
      end
      bmhq_pkg::S_DN_CMP: begin
        state_next = dn_swap ? bmhq_pkg::S_DN : bmhq_pkg::S_FINISH;
      end
      bmhq_pkg::S_UP: begin
        state_next = (pos == '0) ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_CMP;
      end
      bmhq_pkg::S_UP_CMP: begin
        state_next = up_climb ? bmhq_pkg::S_UP : bmhq_pkg::S_FINISH;
      end
      bmhq_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = bmhq_pkg::S_IDLE;
        end
      end
      default: state_next = bmhq_pkg::S_IDLE;
    endcase
  end

  // controller outputs: handshake and memory strobes
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = cur;
    raddr_a   = '0;
    raddr_b   = '0;
    unique case (state)
      bmhq_pkg::S_IDLE: begin
        // root is prefetched for an extract
        in_ready = 1'b1;
      end
      bmhq_pkg::S_EX_ROOT: begin
        // count already points at the last entry
        raddr_a = count[ADDR_W-1:0];
      end
      bmhq_pkg::S_EX_LAST: begin
      end
      bmhq_pkg::S_DN: begin
        if (left_ok) begin
          raddr_a = left_idx[ADDR_W-1:0];
          raddr_b = right_idx[ADDR_W-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        mem_we = 1'b1;
        if (dn_swap) begin
          mem_wdata = pick_entry;
        end
      end
      bmhq_pkg::S_UP: begin
        if (pos == '0) begin
          mem_we = 1'b1;
        end else begin
          raddr_a = parent;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        mem_we = 1'b1;
        if (up_climb) begin
          mem_wdata = rd_a;
        end
      end
      bmhq_pkg::S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmhq_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (kind == bmhq_pkg::KIND_EXTRACT) begin
          if (!empty) begin
            count <= count - 1'b1;
          end
        end else if (!full) begin
          count <= count + 1'b1;
        end
      end
      if (state == bmhq_pkg::S_FINISH && out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          res_key <= '0;
          res_tag <= '0;
          cur     <= {key, tag};
          pos     <= count[ADDR_W-1:0];
          if (kind == bmhq_pkg::KIND_EXTRACT) begin
            res_status <= empty ? bmhq_pkg::STATUS_UNDERFLOW : bmhq_pkg::STATUS_OK;
          end else begin
            res_status <= full ? bmhq_pkg::STATUS_OVERFLOW : bmhq_pkg::STATUS_OK;
          end
        end
      end
      bmhq_pkg::S_EX_ROOT: begin
        res_key <= rd_a[ENTRY_W-1 -: KEY_WIDTH];
        res_tag <= rd_a[TAG_WIDTH-1:0];
      end
      bmhq_pkg::S_EX_LAST: begin
        cur <= rd_a;
        pos <= '0;
      end
      bmhq_pkg::S_DN: begin
        right_ok <= (right_idx < count_ext);
      end
      bmhq_pkg::S_DN_CMP: begin
        if (dn_swap) begin
          pos <= pick_idx;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (up_climb) begin
          pos <= parent;
        end
      end
      bmhq_pkg::S_FINISH: begin
        if (out_load) begin
          out_key    <= res_key;
          out_tag    <= res_tag;
          status     <= res_status;
          fill_count <= count;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `BMHQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `BMHQ_ASSERT_NOW(a_dn_pos_live, state == bmhq_pkg::S_DN_CMP, count_ext > IDX_W'(pos))
  `BMHQ_ASSERT_NEXT(a_insert_grows, accept && kind == bmhq_pkg::KIND_INSERT && !full,
                    count == $past(count) + 1'b1)
  `BMHQ_ASSERT_NEXT(a_underflow_quick, accept && kind == bmhq_pkg::KIND_EXTRACT && empty,
                    state == bmhq_pkg::S_FINISH && count == '0)
  `BMHQ_ASSERT_NOW(a_error_zero_data,
                   out_valid && status != bmhq_pkg::STATUS_OK,
                   out_key == '0 && out_tag == '0)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: binary min-heap priority queue
// Sends insert and extract items through the valid/ready input and checks
// every result item against a heap model kept in the bench. The sequence
// covers empty extracts and full inserts, ties on keys, and extreme keys.
// It also fills the heap to capacity and drains it again. The result side
// stalls at random and holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = bmhq_pkg::DEF_CAPACITY;
  localparam int KW = bmhq_pkg::DEF_KEY_WIDTH;
  localparam int TW = bmhq_pkg::DEF_TAG_WIDTH;
  localparam int FW = $clog2(CAP + 1);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic                 kind;
    logic signed [KW-1:0] key;
    logic [TW-1:0]        tag;
  } heap_op_t;

  typedef struct {
    logic signed [KW-1:0] key;
    logic [TW-1:0]        tag;
    bmhq_pkg::status_t    status;
    logic [FW-1:0]        fill;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = bmhq_pkg::KIND_INSERT;
  logic signed [KW-1:0] key = '0;
  logic [TW-1:0] tag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [KW-1:0] out_key;
  logic [TW-1:0] out_tag;
  logic [1:0] status;
  logic [FW-1:0] fill_count;

  // operations waiting to be sent, and results the heap model predicts
  heap_op_t op_q[$];
  heap_result_t extract_results[$];

  // heap model state
  logic signed [KW-1:0] model_key[CAP];
  logic [TW-1:0] model_tag[CAP];
  int unsigned model_count = 0;

  int unsigned gen_count = 0;
  int unsigned n_ops = 0;
  int unsigned n_taken = 0;
  int unsigned n_results = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle = 0;
  bit hold_done = 1'b0;
  bit failed = 1'b0;
  heap_op_t nxt;

  binary_min_heap_queue #(
    .CAPACITY(CAP),
    .KEY_WIDTH(KW),
    .TAG_WIDTH(TW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .key(key),
    .tag(tag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key(out_key),
    .out_tag(out_tag),
    .status(status),
    .fill_count(fill_count)
  );

  always #5 clk = ~clk;

  // heap model: apply one accepted item and queue its result
  task automatic heap_apply(input logic op_kind, input logic signed [KW-1:0] op_key,
                            input logic [TW-1:0] op_tag);
    heap_result_t r;
    int unsigned pos;
    int unsigned parent;
    int unsigned left;
    int unsigned pick;
    logic signed [KW-1:0] tk;
    logic [TW-1:0] tt;
    r.key = '0;
    r.tag = '0;
    r.status = bmhq_pkg::STATUS_OK;
    if (op_kind == bmhq_pkg::KIND_INSERT) begin
      if (model_count >= CAP) begin
        r.status = bmhq_pkg::STATUS_OVERFLOW;
      end else begin
        model_key[model_count] = op_key;
        model_tag[model_count] = op_tag;
        pos = model_count;
        model_count++;
        // climb while the parent is strictly greater
        while (pos != 0) begin
          parent = (pos - 1) / 2;
          if (!(model_key[parent] > model_key[pos])) break;
          tk = model_key[parent]; tt = model_tag[parent];
          model_key[parent] = model_key[pos]; model_tag[parent] = model_tag[pos];
          model_key[pos] = tk; model_tag[pos] = tt;
          pos = parent;
        end
      end
    end else begin
      if (model_count == 0) begin
        r.status = bmhq_pkg::STATUS_UNDERFLOW;
      end else begin
        r.key = model_key[0];
        r.tag = model_tag[0];
        model_count--;
        model_key[0] = model_key[model_count];
        model_tag[0] = model_tag[model_count];
        pos = 0;
        // descend toward the smaller child, ties going right
        forever begin
          left = 2 * pos + 1;
          if (left >= model_count) break;
          pick = left;
          if (left + 1 < model_count && !(model_key[left + 1] > model_key[left]))
            pick = left + 1;
          if (!(model_key[pos] > model_key[pick])) break;
          tk = model_key[pick]; tt = model_tag[pick];
          model_key[pick] = model_key[pos]; model_tag[pick] = model_tag[pos];
          model_key[pos] = tk; model_tag[pos] = tt;
          pos = pick;
        end
      end
    end
    r.fill = FW'(model_count);
    extract_results = {extract_results, r};
  endtask

  // stimulus helpers
  task automatic push_op(input logic op_kind, input logic signed [KW-1:0] op_key,
                         input logic [TW-1:0] op_tag);
    heap_op_t o;
    o.kind = op_kind;
    o.key = op_key;
    o.tag = op_tag;
    op_q = {op_q, o};
    if (op_kind == bmhq_pkg::KIND_INSERT && gen_count < CAP) gen_count++;
    if (op_kind == bmhq_pkg::KIND_EXTRACT && gen_count > 0) gen_count--;
  endtask

  function automatic logic signed [KW-1:0] rand_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return KW'($urandom);
    // narrow range to force ties
    if (sel < 7) return KW'(int'($urandom_range(0, 8)) - 4);
    // whole Q16.16 values
    if (sel < 8) return KW'((int'($urandom_range(0, 15)) - 8) * 65536);
    case ($urandom_range(0, 3))
      0: return {1'b1, {(KW-1){1'b0}}};
      1: return {1'b0, {(KW-1){1'b1}}};
      2: return '1;
      default: return '0;
    endcase
  endfunction

  function automatic logic pick_kind(input int unsigned pct_insert);
    return ($urandom_range(0, 99) < pct_insert) ? bmhq_pkg::KIND_INSERT
                                                : bmhq_pkg::KIND_EXTRACT;
  endfunction

  task automatic gen_mix(input int unsigned n, input int unsigned pct_insert);
    for (int unsigned i = 0; i < n; i++)
      push_op(pick_kind(pct_insert), rand_key(), TW'($urandom));
  endtask

  // driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        heap_apply(kind, key, tag);
        n_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_q.size() > 0) begin
          nxt = op_q.pop_front();
          in_valid <= 1'b1;
          kind <= nxt.kind;
          key <= nxt.key;
          tag <= nxt.tag;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // receiver: checks result items and stalls on its own pattern
  always @(posedge clk) begin
    heap_result_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid && out_ready) begin
        n_results++;
        if (extract_results.size() == 0) begin
          $error("result item with none outstanding: key %0d tag %0d status %0d",
                 out_key, out_tag, status);
          failed = 1'b1;
        end else begin
          w = extract_results.pop_front();
          check_field("out_key", w.key, out_key);
          check_field("out_tag", w.tag, out_tag);
          check_field("status", w.status, status);
          check_field("fill_count", w.fill, fill_count);
        end
        if (n_results == HOLD_AT && !hold_done) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      // long hold-off once, otherwise one of four ready modes in turn
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 500) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= rx_cycle[0];
          2: out_ready <= ($urandom_range(0, 9) < 7);
          default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // directed: empty extract, extreme and tied keys, drain past empty
    push_op(bmhq_pkg::KIND_EXTRACT, '0, '0);
    push_op(bmhq_pkg::KIND_INSERT, {1'b0, {(KW-1){1'b1}}}, '1);
    push_op(bmhq_pkg::KIND_INSERT, {1'b1, {(KW-1){1'b0}}}, '0);
    push_op(bmhq_pkg::KIND_INSERT, '0, TW'('h155));
    push_op(bmhq_pkg::KIND_INSERT, '1, TW'('h2aa));
    push_op(bmhq_pkg::KIND_INSERT, '0, TW'(5));
    push_op(bmhq_pkg::KIND_INSERT, '0, TW'(6));
    push_op(bmhq_pkg::KIND_INSERT, KW'(32'h0001_0000), TW'(7));
    push_op(bmhq_pkg::KIND_INSERT, KW'(-32'sh0000_8000), TW'(8));
    for (int i = 0; i < 9; i++)
      push_op(bmhq_pkg::KIND_EXTRACT, KW'($urandom), TW'($urandom));

    // random mix alternating between two insert ratios
    for (int i = 0; i < 6; i++)
      gen_mix(30, (i % 2 == 0) ? 70 : 35);

    // fill to capacity, then push against the full heap
    while (gen_count < CAP)
      push_op(pick_kind(97), rand_key(), TW'($urandom));
    for (int i = 0; i < 4; i++)
      push_op(bmhq_pkg::KIND_INSERT, rand_key(), TW'($urandom));
    gen_mix(60, 60);

    // drain to empty, then extract from the empty heap
    while (gen_count > 0)
      push_op(pick_kind(3), rand_key(), TW'($urandom));
    for (int i = 0; i < 3; i++)
      push_op(bmhq_pkg::KIND_EXTRACT, rand_key(), TW'($urandom));
    gen_mix(60, 50);
    n_ops = op_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (n_taken < n_ops) @(posedge clk);
    while (extract_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (failed) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
